@@ sv/hes_pkg.sv @@
// Shared types and constants for the HTML escape stream block.
package hes_pkg;

    localparam int MAX_RES     = 9;
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int IDX_W       = $clog2(MAX_RES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_TEXT    = 2'd0;
    localparam logic [1:0] MODE_ATTR    = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_DASH = 8'h2D;

    // Byte strings, stored last character first so byte 0 sits in the low bits
    localparam logic [39:0] ENT_AMP        = ";pma&";
    localparam logic [31:0] ENT_LT         = ";tl&";
    localparam logic [31:0] ENT_GT         = ";tg&";
    localparam logic [47:0] ENT_QUOT       = ";touq&";
    localparam logic [31:0] TXT_OPEN       = "--!<";
    localparam logic [23:0] TXT_CLOSE      = ">--";
    localparam logic [39:0] TXT_CLOSE_DASH = ">-- -";
    localparam logic [23:0] TXT_EMDASH     = 24'h9480E2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] in_byte;
        logic       has_byte;
        logic       first;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } job_t;

endpackage

@@ sv/html_escape_stream_core.sv @@
// Top level of the HTML escape stream block.
// A word with output bytes, accepted into an empty queue, shows its first byte in the
// next cycle. One input word per cycle while each yields a single byte and pop stays
// high; a word of n bytes holds the output for n pops, absorbed by a two-entry job queue.
// Reset: asynchronous, active low; clears the pending dash, the queue and the byte index.
module html_escape_stream_core #(
    parameter int QDEPTH = hes_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hes_pkg::in_word_t  item,
    input  logic               push,
    output logic               full,
    output hes_pkg::out_word_t result,
    output logic               empty,
    input  logic               pop
);
    import hes_pkg::*;

    job_t job;
    job_t head;
    logic job_valid;
    logic accept;
    logic head_empty;
    logic head_pop;
    logic dash_pending;

    assign accept = push && !full;

    hes_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .accept       (accept),
        .job          (job),
        .job_valid    (job_valid),
        .dash_pending (dash_pending)
    );

    hes_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && job_valid),
        .wr_data (job),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .empty   (head_empty)
    );

    hes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty together");

    a_last_clears_dash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> !dash_pending)
        else $error("dash still pending after last word of a string");

    a_plain_clears_dash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode != MODE_COMMENT)) |=> !dash_pending)
        else $error("dash pending after non-comment word");

    a_byte_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && item.has_byte && (item.mode != MODE_COMMENT)) |=> !empty)
        else $error("escaped byte did not reach the output");

endmodule

@@ sv/hes_front.sv @@
// Front end: classifies each input word and builds its output byte job.
module hes_front (
    input  logic             clk,
    input  logic             rst_n,
    input  hes_pkg::in_word_t item,
    input  logic             accept,
    output hes_pkg::job_t    job,
    output logic             job_valid,
    output logic             dash_pending
);
    import hes_pkg::*;

    logic        dash_held_reg;
    logic        dash_held_next;
    logic        dash_in;
    logic        dash_mid;
    logic [31:0] pre_vec;
    logic [2:0]  pre_len;
    logic [47:0] body_vec;
    logic [2:0]  body_len;
    logic [39:0] suf_vec;
    logic [2:0]  suf_len;
    logic [2:0]  off_body;
    logic [3:0]  off_suf;

    always_comb
    begin
        dash_in  = item.first ? 1'b0 : dash_held_reg;
        dash_mid = 1'b0;
        pre_vec  = '0;
        pre_len  = '0;
        body_vec = '0;
        body_len = '0;
        suf_vec  = '0;
        suf_len  = '0;
        if (item.mode == MODE_COMMENT)
        begin
            dash_mid = dash_in;
            if (item.first)
            begin
                pre_vec = TXT_OPEN;
                pre_len = 3'd4;
            end
            if (item.has_byte)
            begin
                if (item.in_byte == CH_DASH)
                begin
                    if (dash_in)
                    begin
                        body_vec = 48'(TXT_EMDASH);
                        body_len = 3'd3;
                        dash_mid = 1'b0;
                    end
                    else
                    begin
                        dash_mid = 1'b1;
                    end
                end
                else
                begin
                    if (dash_in)
                    begin
                        body_vec = {32'h0, item.in_byte, CH_DASH};
                        body_len = 3'd2;
                    end
                    else
                    begin
                        body_vec = {40'h0, item.in_byte};
                        body_len = 3'd1;
                    end
                    dash_mid = 1'b0;
                end
            end
            if (item.last)
            begin
                if (dash_mid)
                begin
                    suf_vec = TXT_CLOSE_DASH;
                    suf_len = 3'd5;
                end
                else
                begin
                    suf_vec = 40'(TXT_CLOSE);
                    suf_len = 3'd3;
                end
                dash_mid = 1'b0;
            end
        end
        else if (item.has_byte)
        begin
            case (item.in_byte)
                CH_AMP:
                begin
                    body_vec = 48'(ENT_AMP);
                    body_len = 3'd5;
                end
                CH_LT:
                begin
                    body_vec = 48'(ENT_LT);
                    body_len = 3'd4;
                end
                CH_GT:
                begin
                    body_vec = 48'(ENT_GT);
                    body_len = 3'd4;
                end
                CH_QUOT:
                begin
                    if (item.mode == MODE_ATTR)
                    begin
                        body_vec = ENT_QUOT;
                        body_len = 3'd6;
                    end
                    else
                    begin
                        body_vec = {40'h0, item.in_byte};
                        body_len = 3'd1;
                    end
                end
                default:
                begin
                    body_vec = {40'h0, item.in_byte};
                    body_len = 3'd1;
                end
            endcase
        end
        dash_held_next = accept ? dash_mid : dash_held_reg;
    end

    assign off_body = pre_len;
    assign off_suf  = {1'b0, pre_len} + {1'b0, body_len};

    assign job.bytes = (8*MAX_RES)'(pre_vec)
                     | ((8*MAX_RES)'(body_vec) << {off_body, 3'b000})
                     | ((8*MAX_RES)'(suf_vec) << {off_suf, 3'b000});
    assign job.count = CNT_W'(pre_len) + CNT_W'(body_len) + CNT_W'(suf_len);
    assign job_valid = (job.count != '0);
    assign dash_pending = dash_held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_held_reg <= 1'b0;
        end
        else
        begin
            dash_held_reg <= dash_held_next;
        end
    end

endmodule

@@ sv/hes_fifo.sv @@
// Short job queue between the front end and the byte serialiser.
module hes_fifo #(
    parameter int DEPTH = hes_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  hes_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output hes_pkg::job_t rd_data,
    output logic          empty
);
    import hes_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/hes_back.sv @@
// Back end: serialises the head job one output word per pop.
module hes_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hes_pkg::job_t      head,
    input  logic               head_empty,
    output logic               head_pop,
    output hes_pkg::out_word_t result,
    output logic               empty,
    input  logic               pop
);
    import hes_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             take;

    assign empty           = head_empty;
    assign result.out_byte = head.bytes[idx_reg];
    assign result.out_last = (CNT_W'(idx_reg) == head.count - 1'b1);
    assign take            = pop && !head_empty;
    assign head_pop        = take && result.out_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = result.out_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for html_escape_stream_core: scoreboard class, directed and random string words.
`timescale 1ns / 1ps

module testbench;
    import hes_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         N_WORDS    = 200;
    localparam int         CALM_FROM  = 170;
    localparam int         IN_W       = $bits(in_word_t);

    class escape_checker;
        out_word_t  due_bytes[$];
        logic [7:0] word_bytes[$];
        bit         dash_pending;
        int         mismatches;

        task log_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function void add_byte(logic [7:0] b);
            word_bytes.push_back(b);
        endfunction

        function void add_text(string s);
            for (int i = 0; i < s.len(); i++)
                add_byte(s[i]);
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            word_bytes.delete();
            if (w.first)
                dash_pending = 1'b0;
            if (w.mode == MODE_COMMENT)
            begin
                if (w.first)
                    add_text("<!--");
                if (w.has_byte)
                begin
                    if (w.in_byte == CH_DASH)
                    begin
                        if (dash_pending)
                        begin
                            // em dash in UTF-8
                            add_byte(8'hE2);
                            add_byte(8'h80);
                            add_byte(8'h94);
                            dash_pending = 1'b0;
                        end
                        else
                            dash_pending = 1'b1;
                    end
                    else
                    begin
                        if (dash_pending)
                        begin
                            add_byte(CH_DASH);
                            dash_pending = 1'b0;
                        end
                        add_byte(w.in_byte);
                    end
                end
                if (w.last)
                begin
                    if (dash_pending)
                        add_text("- -->");
                    else
                        add_text("-->");
                    dash_pending = 1'b0;
                end
            end
            else
            begin
                dash_pending = 1'b0;
                if (w.has_byte)
                begin
                    case (w.in_byte)
                        CH_AMP:  add_text("&amp;");
                        CH_LT:   add_text("&lt;");
                        CH_GT:   add_text("&gt;");
                        CH_QUOT:
                        begin
                            if (w.mode == MODE_ATTR)
                                add_text("&quot;");
                            else
                                add_byte(w.in_byte);
                        end
                        default: add_byte(w.in_byte);
                    endcase
                end
            end
            foreach (word_bytes[i])
            begin
                r.out_byte = word_bytes[i];
                r.out_last = (i == word_bytes.size() - 1);
                due_bytes.push_back(r);
            end
        endfunction

        task check_result(out_word_t r);
            out_word_t want;
            if (due_bytes.size() == 0)
                log_mismatch($sformatf("unexpected byte %h last %b", r.out_byte, r.out_last));
            else
            begin
                want = due_bytes.pop_front();
                if (r.out_byte !== want.out_byte)
                    log_mismatch($sformatf("out_byte %h, want %h", r.out_byte, want.out_byte));
                if (r.out_last !== want.out_last)
                    log_mismatch($sformatf("out_last %b, want %b", r.out_last, want.out_last));
            end
        endtask
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    in_word_t  item  = '0;
    logic      push  = 1'b0;
    logic      full;
    out_word_t result;
    logic      empty;
    logic      pop   = 1'b0;

    bit            calm       = 1'b0;
    int            words_sent = 0;
    escape_checker chk        = new;

    html_escape_stream_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic in_word_t make_word(logic [1:0] m, logic [7:0] b, logic has,
                                           logic fst, logic lst);
        in_word_t w;
        w.mode     = m;
        w.in_byte  = b;
        w.has_byte = has;
        w.first    = fst;
        w.last     = lst;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        chk.note_word(w);
        if (w.has_byte || w.first || w.last)
            words_sent++;
        if (words_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    task automatic drain_all();
        push <= 1'b0;
        do
            @(posedge clk);
        while (chk.due_bytes.size() != 0);
    endtask

    initial
    begin : drain
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                    chk.check_result(result);
                if (stall_left > 0)
                begin
                    stall_left--;
                    pop <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(0, 10);
                    pop <= 1'b0;
                end
                else
                    pop <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        in_word_t   w;
        logic [1:0] m;
        logic [7:0] b;
        int         len;
        bit         broken;
        bit         tail_empty;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(MODE_TEXT, CH_AMP, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_TEXT, CH_LT, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_TEXT, CH_GT, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_TEXT, CH_QUOT, 1'b1, 1'b0, 1'b1));
        send_word(make_word(MODE_ATTR, CH_QUOT, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_ATTR, 8'h01, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_ATTR, 8'hFF, 1'b1, 1'b0, 1'b1));
        send_word(make_word(MODE_SPARE, CH_LT, 1'b1, 1'b1, 1'b1));
        send_word(make_word(MODE_TEXT, 8'h00, 1'b0, 1'b1, 1'b1));
        send_word(make_word(MODE_COMMENT, 8'h00, 1'b0, 1'b1, 1'b1));
        send_word(make_word(MODE_COMMENT, 8'h61, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_COMMENT, 8'h62, 1'b1, 1'b0, 1'b0));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b0, 1'b1));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_COMMENT, 8'h78, 1'b1, 1'b1, 1'b1));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_TEXT, 8'h71, 1'b1, 1'b0, 1'b1));
        send_word(make_word(MODE_TEXT, 8'h00, 1'b1, 1'b1, 1'b1));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b1, 1'b0));
        send_word(make_word(MODE_COMMENT, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_word(make_word(MODE_COMMENT, CH_DASH, 1'b1, 1'b0, 1'b1));

        drain_all();

        while (words_sent < N_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                w = IN_W'($urandom);
                send_word(w);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: m = MODE_COMMENT;
                    4, 7:       m = MODE_TEXT;
                    5:          m = MODE_ATTR;
                    default:    m = MODE_SPARE;
                endcase
                len = $urandom_range(0, 7);
                if (len == 0)
                    send_word(make_word(m, 8'($urandom), 1'b0, 1'b1, 1'b1));
                else
                begin
                    broken     = ($urandom_range(0, 9) == 0);
                    tail_empty = ($urandom_range(0, 3) == 0);
                    for (int i = 0; i < len; i++)
                    begin
                        if (i > 0 && $urandom_range(0, 7) == 0)
                            send_word(make_word(m, 8'($urandom), 1'b0, 1'b0, 1'b0));
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: b = CH_DASH;
                            4:          b = CH_AMP;
                            5:          b = CH_LT;
                            6:          b = CH_GT;
                            7:          b = CH_QUOT;
                            default:    b = 8'($urandom_range(1, 255));
                        endcase
                        send_word(make_word(m, b, 1'b1, i == 0,
                                            i == len - 1 && !broken && !tail_empty));
                    end
                    if (tail_empty && !broken)
                        send_word(make_word(m, 8'($urandom), 1'b0, 1'b0, 1'b1));
                end
            end
        end

        drain_all();
        repeat (20) @(posedge clk);
        if (chk.mismatches == 0 && chk.due_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
